// File: design/mcs_pkg.sv
// shared definitions for the min/max contrast stretch block
// widths, register indexes and the control state type
// no dependencies
package mcs_pkg;

  localparam int PIXEL_BITS = 16;
  localparam int PORT_BITS  = 16;
  localparam int OUT_BITS   = 8;
  localparam int NUM_BITS   = PIXEL_BITS + OUT_BITS;
  localparam int CNT_BITS   = $clog2(OUT_BITS);
  localparam int IDX_BITS   = 2;

  localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(OUT_BITS - 1);
  localparam logic [OUT_BITS-1:0] OUT_TOP   = {OUT_BITS{1'b1}};

  localparam logic [IDX_BITS-1:0] REG_AUTO_RANGE = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_FIXED_MIN  = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_FIXED_MAX  = 2'd2;
  localparam logic [IDX_BITS-1:0] REG_NODATA     = 2'd3;

  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_RESCALE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_HOLD
  } state_t;

endpackage

// File: design/minmax_contrast_stretch.sv
// min/max linear contrast stretch, 16-bit pixels to 8-bit output
// uses mcs_pkg; division runs one quotient bit per cycle
//
// input stream: s_axis_tdata carries the pixel, s_axis_tuser carries op and
// first. op 0 (measure) updates the tracked min and max and gives no output;
// first clears the tracked range to the no-data value. op 1 (rescale) gives
// one output transfer with the stretched byte and the bounds that were used.
// a measure transfer leaves the block in idle; the next item is taken right after.
// a rescale transfer runs a restoring divider, one quotient bit per cycle, and
// no new item is taken until the block is back in the idle state.
// rescales that hit a clamp or equal bounds skip the divider and go to hold.
// the output sits in a register: while it waits for m_axis_tready the block
// keeps taking measure items and starts the next rescale; a finished result
// waits in the quotient register until the output register frees up.
// a divided rescale loads the output from the last divider step, or from hold.
// reset (rst, synchronous) restores the registers to auto range, fixed range
// 0..65535, no-data 0, and clears the tracked range and the output valid.
// configuration writes (cfg_we) are taken at any edge, meant while idle.
module minmax_contrast_stretch
  import mcs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [IDX_BITS-1:0]  cfg_index,
  input  logic [PORT_BITS-1:0] cfg_data,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [15:0]          s_axis_tdata,  // pixel
  input  logic [1:0]           s_axis_tuser,  // op, first
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [39:0]          m_axis_tdata   // out_byte, used_min, used_max
);

  // configuration
  logic                  auto_range;
  logic [PIXEL_BITS-1:0] fixed_min;
  logic [PIXEL_BITS-1:0] fixed_max;
  logic [PIXEL_BITS-1:0] nodata_value;

  // tracked range
  logic                  seen_valid;
  logic [PIXEL_BITS-1:0] run_min;
  logic [PIXEL_BITS-1:0] run_max;

  // rescale work registers
  state_t                state;
  state_t                state_next;
  logic [CNT_BITS-1:0]   cnt;
  logic [PIXEL_BITS-1:0] lo;
  logic [PIXEL_BITS-1:0] hi;
  logic [PIXEL_BITS-1:0] rem;
  logic [PIXEL_BITS-1:0] dsr;
  logic [OUT_BITS-1:0]   num_lo;
  logic [OUT_BITS-1:0]   q;

  // output register
  logic                  out_valid;
  logic [OUT_BITS-1:0]   out_byte;
  logic [PIXEL_BITS-1:0] used_min;
  logic [PIXEL_BITS-1:0] used_max;

  // control
  logic                  in_xfer;
  logic                  in_op;
  logic                  in_first;
  logic [PIXEL_BITS-1:0] pix;
  logic                  slot_free;
  logic                  load_out;
  logic                  last_step;
  logic                  take_div;

  // measure path
  logic [PIXEL_BITS-1:0] base_min;
  logic [PIXEL_BITS-1:0] base_max;
  logic                  base_seen;

  // rescale setup path
  logic [PIXEL_BITS-1:0] sel_lo;
  logic [PIXEL_BITS-1:0] sel_hi;
  logic                  special;
  logic [OUT_BITS-1:0]   special_byte;
  logic [PIXEL_BITS-1:0] diff;
  logic [NUM_BITS-1:0]   num;

  // divider step
  logic [PIXEL_BITS:0]   r_sh;
  logic                  qbit;
  logic [PIXEL_BITS:0]   r_sub;
  logic [OUT_BITS-1:0]   q_shift;

  assign in_op     = s_axis_tuser[0];
  assign in_first  = s_axis_tuser[1];
  assign pix       = s_axis_tdata[PIXEL_BITS-1:0];
  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign slot_free = !out_valid || m_axis_tready;
  assign last_step = (cnt == LAST_STEP);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      auto_range   <= 1'b1;
      fixed_min    <= '0;
      fixed_max    <= '1;
      nodata_value <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AUTO_RANGE: auto_range   <= cfg_data[0];
        REG_FIXED_MIN:  fixed_min    <= cfg_data[PIXEL_BITS-1:0];
        REG_FIXED_MAX:  fixed_max    <= cfg_data[PIXEL_BITS-1:0];
        REG_NODATA:     nodata_value <= cfg_data[PIXEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // measure: range after an optional clear, then fold in the pixel
  always_comb begin
    base_min  = in_first ? nodata_value : run_min;
    base_max  = in_first ? nodata_value : run_max;
    base_seen = in_first ? 1'b0 : seen_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_valid <= 1'b0;
      run_min    <= '0;
      run_max    <= '0;
    end else if (in_xfer && in_op == OP_MEASURE) begin
      if (pix == nodata_value) begin
        seen_valid <= base_seen;
        run_min    <= base_min;
        run_max    <= base_max;
      end else if (!base_seen) begin
        seen_valid <= 1'b1;
        run_min    <= pix;
        run_max    <= pix;
      end else begin
        seen_valid <= 1'b1;
        run_min    <= (pix < base_min) ? pix : base_min;
        run_max    <= (pix > base_max) ? pix : base_max;
      end
    end
  end

  // rescale setup: bounds, clamps and the scaled numerator (diff * 255)
  always_comb begin
    if (!auto_range) begin
      sel_lo = fixed_min;
      sel_hi = fixed_max;
    end else if (seen_valid) begin
      sel_lo = run_min;
      sel_hi = run_max;
    end else begin
      sel_lo = nodata_value;
      sel_hi = nodata_value;
    end
    special = (sel_hi == sel_lo) || (pix < sel_lo) || (pix > sel_hi);
    priority if (sel_hi == sel_lo) begin
      special_byte = sel_lo[OUT_BITS-1:0];
    end else if (pix < sel_lo) begin
      special_byte = '0;
    end else begin
      special_byte = OUT_TOP;
    end
    diff = pix - sel_lo;
    num  = {diff, {OUT_BITS{1'b0}}} - {{OUT_BITS{1'b0}}, diff};
  end

  assign take_div = in_xfer && in_op == OP_RESCALE && !special;

  // restoring division step, remainder stays below the divisor
  always_comb begin
    r_sh    = {rem, num_lo[OUT_BITS-1]};
    qbit    = (r_sh >= {1'b0, dsr});
    r_sub   = r_sh - {1'b0, dsr};
    q_shift = {q[OUT_BITS-2:0], qbit};
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer && in_op == OP_RESCALE) begin
          state_next = special ? ST_HOLD : ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (last_step) begin
          state_next = slot_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    unique case (state)
      ST_IDLE:   s_axis_tready = 1'b1;
      ST_DIVIDE: load_out      = last_step && slot_free;
      ST_HOLD:   load_out      = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_DIVIDE) begin
        cnt <= last_step ? '0 : cnt + 1'b1;
      end
    end
  end

  // work registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer && in_op == OP_RESCALE) begin
      lo     <= sel_lo;
      hi     <= sel_hi;
      dsr    <= sel_hi - sel_lo;
      rem    <= num[NUM_BITS-1:OUT_BITS];
      num_lo <= num[OUT_BITS-1:0];
      q      <= special ? special_byte : '0;
    end else if (state == ST_DIVIDE) begin
      rem    <= qbit ? r_sub[PIXEL_BITS-1:0] : r_sh[PIXEL_BITS-1:0];
      num_lo <= {num_lo[OUT_BITS-2:0], 1'b0};
      q      <= q_shift;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_byte <= (state == ST_DIVIDE) ? q_shift : q;
      used_min <= lo;
      used_max <= hi;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {PORT_BITS'(used_max), PORT_BITS'(used_min), out_byte};

  // checks
  a_rescale_busy: assert property (@(posedge clk) disable iff (rst)
    in_xfer && in_op == OP_RESCALE |=> !s_axis_tready)
    else $error("input taken during a rescale");

  a_measure_idle: assert property (@(posedge clk) disable iff (rst)
    in_xfer && in_op == OP_MEASURE |=> state == ST_IDLE)
    else $error("measure left the idle state");

  a_rem_below_dsr: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIVIDE |-> rem < dsr)
    else $error("divider remainder not below divisor");

  a_range_order: assert property (@(posedge clk) disable iff (rst)
    seen_valid |-> run_min <= run_max)
    else $error("tracked min above tracked max");

  a_div_starts: assert property (@(posedge clk) disable iff (rst)
    take_div |=> state == ST_DIVIDE && cnt == '0)
    else $error("division did not start at step zero");

endmodule

// File: test/minmax_contrast_stretch_tb.sv
`timescale 1ns / 1ps
// testbench for minmax_contrast_stretch: measure and rescale streams checked
// against an in-bench predictor of the stretch; depends on mcs_pkg and the rtl
module minmax_contrast_stretch_tb;
  import mcs_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic        op;
    logic        first;
    logic [15:0] pixel;
  } pix_req_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [15:0] used_min;
    logic [15:0] used_max;
  } stretch_res_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [IDX_BITS-1:0]  cfg_index = '0;
  logic [PORT_BITS-1:0] cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [15:0]          s_tdata = '0;  // pixel
  logic [1:0]           s_tuser = '0;  // op, first
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [39:0]          m_tdata;       // out_byte, used_min, used_max

  minmax_contrast_stretch i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  // predictor copy of registers and tracked range
  logic        cfg_auto = 1'b1;
  logic [15:0] cfg_fmin = 16'd0;
  logic [15:0] cfg_fmax = 16'hFFFF;
  logic [15:0] cfg_nodata = 16'd0;
  logic [15:0] trk_min = 16'd0;
  logic [15:0] trk_max = 16'd0;
  logic        trk_valid = 1'b0;

  pix_req_t     pix_queue[$];
  stretch_res_t stretch_expect[$];
  pix_req_t     on_bus;
  int           snd_idle = 0;
  int           rcv_idle = 0;
  int           mismatch_cnt = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  function automatic logic [7:0] stretch_byte(logic [15:0] v, logic [15:0] lo,
                                               logic [15:0] hi);
    int unsigned num;
    int unsigned den;
    if (hi == lo) return lo[7:0];
    if (v < lo) return 8'd0;
    if (v > hi) return OUT_TOP;
    num = (32'(v) - 32'(lo)) * 32'(OUT_TOP);
    den = 32'(hi) - 32'(lo);
    return 8'(num / den);
  endfunction

  task automatic model_pixel(pix_req_t it);
    logic [15:0]  lo;
    logic [15:0]  hi;
    stretch_res_t r;
    if (it.op == OP_MEASURE) begin
      if (it.first) begin
        trk_min = cfg_nodata;
        trk_max = cfg_nodata;
        trk_valid = 1'b0;
      end
      if (it.pixel != cfg_nodata) begin
        if (!trk_valid) begin
          trk_min = it.pixel;
          trk_max = it.pixel;
          trk_valid = 1'b1;
        end else begin
          if (it.pixel < trk_min) trk_min = it.pixel;
          if (it.pixel > trk_max) trk_max = it.pixel;
        end
      end
    end else begin
      if (cfg_auto) begin
        lo = trk_valid ? trk_min : cfg_nodata;
        hi = trk_valid ? trk_max : cfg_nodata;
      end else begin
        lo = cfg_fmin;
        hi = cfg_fmax;
      end
      r.out_byte = stretch_byte(it.pixel, lo, hi);
      r.used_min = lo;
      r.used_max = hi;
      stretch_expect.push_back(r);
    end
  endtask

  // sender: a new pixel goes up only once the previous transfer is done
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) model_pixel(on_bus);
      if (!s_tvalid || s_tready) begin
        if (pix_queue.size() > 0 && $urandom_range(99) >= snd_idle) begin
          on_bus = pix_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= on_bus.pixel;
          s_tuser <= {on_bus.first, on_bus.op};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  always @(posedge clk) begin
    stretch_res_t got;
    stretch_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.out_byte = m_tdata[7:0];
      got.used_min = m_tdata[23:8];
      got.used_max = m_tdata[39:24];
      if (stretch_expect.size() == 0) begin
        $error("unexpected result transfer: out_byte %0d used_min %0d used_max %0d",
               got.out_byte, got.used_min, got.used_max);
        mismatch_cnt++;
      end else begin
        want = stretch_expect.pop_front();
        if (got.out_byte !== want.out_byte) begin
          $error("out_byte expected %0d got %0d", want.out_byte, got.out_byte);
          mismatch_cnt++;
        end
        if (got.used_min !== want.used_min) begin
          $error("used_min expected %0d got %0d", want.used_min, got.used_min);
          mismatch_cnt++;
        end
        if (got.used_max !== want.used_max) begin
          $error("used_max expected %0d got %0d", want.used_max, got.used_max);
          mismatch_cnt++;
        end
      end
    end
  end

  task automatic push_pixel(logic op, logic first, logic [15:0] pixel);
    pix_req_t it;
    it.op = op;
    it.first = first;
    it.pixel = pixel;
    pix_queue.push_back(it);
  endtask

  // measure items give no result, so let the pipeline settle after the last one
  task automatic wait_idle();
    do @(negedge clk);
    while (pix_queue.size() != 0 || s_tvalid || stretch_expect.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [IDX_BITS-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  task automatic load_settings(logic auto_on, logic [15:0] fmin, logic [15:0] fmax,
                               logic [15:0] nodata);
    wait_idle();
    write_reg(REG_AUTO_RANGE, {15'd0, auto_on});
    write_reg(REG_FIXED_MIN, fmin);
    write_reg(REG_FIXED_MAX, fmax);
    write_reg(REG_NODATA, nodata);
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_auto = auto_on;
    cfg_fmin = fmin;
    cfg_fmax = fmax;
    cfg_nodata = nodata;
  endtask

  function automatic int random_span();
    case ($urandom_range(2))
      0: return $urandom_range(3);
      1: return $urandom_range(300);
      default: return $urandom_range(65535);
    endcase
  endfunction

  task automatic pick_settings(int kind);
    int          span;
    logic [15:0] fmin;
    logic [15:0] fmax;
    logic [15:0] nodata;
    fmin = 16'($urandom);
    fmax = 16'($urandom);
    nodata = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom);
    case (kind)
      0: load_settings(1'b1, fmin, fmax, 16'd0);
      1: load_settings(1'b1, fmin, fmax, nodata);
      2: begin
        span = random_span();
        fmin = 16'($urandom_range(65535 - span));
        fmax = 16'(fmin + span);
        load_settings(1'b0, fmin, fmax, nodata);
      end
      default: begin
        if ($urandom_range(3) == 0) fmax = fmin;
        load_settings(1'b0, fmin, fmax, nodata);
      end
    endcase
  endtask

  // mostly a measure pass followed by a rescale pass around the same window,
  // with some rescale-only runs and some random noise
  task automatic add_pixels(int n);
    int          made;
    int          len;
    int          span;
    int          win_lo;
    int          win_hi;
    int          sel;
    logic [15:0] px;
    made = 0;
    while (made < n) begin
      sel = $urandom_range(9);
      if (sel == 0) begin
        len = $urandom_range(4, 1);
        for (int i = 0; i < len; i++) begin
          px = ($urandom_range(3) == 0) ? cfg_nodata : 16'($urandom);
          push_pixel(1'($urandom_range(1)), 1'($urandom_range(1)), px);
        end
        made += len;
      end else begin
        span = random_span();
        win_lo = $urandom_range(65535 - span);
        win_hi = win_lo + span;
        if (sel != 1) begin
          len = $urandom_range(8, 1);
          for (int i = 0; i < len; i++) begin
            px = ($urandom_range(6) == 0) ? cfg_nodata : 16'(win_lo + $urandom_range(span));
            push_pixel(OP_MEASURE, i == 0, px);
          end
          made += len;
        end
        if (!cfg_auto && cfg_fmin <= cfg_fmax) begin
          win_lo = cfg_fmin;
          win_hi = cfg_fmax;
        end
        len = $urandom_range(8, 1);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(5))
            0: px = (win_lo == 0) ? 16'd0 : 16'($urandom_range(win_lo - 1));
            1: px = (win_hi == 65535) ? 16'hFFFF : 16'($urandom_range(65535, win_hi + 1));
            2: px = 16'($urandom);
            default: px = 16'($urandom_range(win_hi, win_lo));
          endcase
          push_pixel(OP_RESCALE, 1'($urandom_range(1)), px);
        end
        made += len;
      end
    end
  endtask

  initial begin
    snd_idle = 32;
    rcv_idle = 71;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: nothing measured yet, so no-data bounds apply
    push_pixel(OP_RESCALE, 1'b1, 16'd1234);
    push_pixel(OP_MEASURE, 1'b1, 16'd0);
    push_pixel(OP_RESCALE, 1'b0, 16'hFFFF);
    push_pixel(OP_MEASURE, 1'b0, 16'd100);
    push_pixel(OP_MEASURE, 1'b0, 16'hFFFF);
    push_pixel(OP_MEASURE, 1'b0, 16'd0);
    push_pixel(OP_MEASURE, 1'b0, 16'd40000);
    push_pixel(OP_RESCALE, 1'b0, 16'd0);
    push_pixel(OP_RESCALE, 1'b0, 16'd100);
    push_pixel(OP_RESCALE, 1'b1, 16'hFFFF);
    push_pixel(OP_RESCALE, 1'b0, 16'd32817);
    // single valid pixel gives equal bounds
    push_pixel(OP_MEASURE, 1'b1, 16'd7);
    push_pixel(OP_RESCALE, 1'b0, 16'd7);
    push_pixel(OP_RESCALE, 1'b0, 16'd8);

    // inverted fixed range, measuring still goes on underneath
    load_settings(1'b0, 16'd1000, 16'd200, 16'hFFFF);
    push_pixel(OP_RESCALE, 1'b0, 16'd999);
    push_pixel(OP_RESCALE, 1'b0, 16'd1000);
    push_pixel(OP_RESCALE, 1'b0, 16'hFFFF);
    push_pixel(OP_MEASURE, 1'b1, 16'hFFFF);
    push_pixel(OP_MEASURE, 1'b0, 16'd5);
    load_settings(1'b0, 16'h1234, 16'h1234, 16'hFFFF);
    push_pixel(OP_RESCALE, 1'b0, 16'd0);
    load_settings(1'b0, 16'd0, 16'hFFFF, 16'hFFFF);
    push_pixel(OP_RESCALE, 1'b0, 16'd0);
    push_pixel(OP_RESCALE, 1'b0, 16'hFFFF);
    push_pixel(OP_RESCALE, 1'b0, 16'd32768);
    load_settings(1'b1, 16'd0, 16'hFFFF, 16'hFFFF);
    push_pixel(OP_RESCALE, 1'b0, 16'd3);
    push_pixel(OP_MEASURE, 1'b1, 16'hFFFF);
    push_pixel(OP_RESCALE, 1'b0, 16'd3);

    for (int mode = 0; mode < 3; mode++) begin
      for (int kind = 0; kind < 4; kind++) begin
        pick_settings(kind);
        // switch idling only once the bus is quiet
        snd_idle = (mode == 0) ? 32 : (mode == 1) ? 71 : 0;
        rcv_idle = (mode == 0) ? 71 : (mode == 1) ? 32 : 0;
        add_pixels(130);
      end
    end

    wait_idle();
    if (mismatch_cnt == 0 && stretch_expect.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
